// ===== src/audio_voice_allocator_top_defines.svh =====
// ----------------------------------------------------------------------------
// audio voice allocator assertion macros
// shared concurrent assertion forms for the allocator rtl
// ----------------------------------------------------------------------------
`ifndef AUDIO_VOICE_ALLOCATOR_TOP_DEFINES_SVH
`define AUDIO_VOICE_ALLOCATOR_TOP_DEFINES_SVH

// checked only outside reset
`define AVA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every edge, reset included
`define AVA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== src/ava_pkg.sv =====
// ----------------------------------------------------------------------------
// ava_pkg
// types, codes and constants of the audio voice allocator
// ----------------------------------------------------------------------------
`default_nettype none

package ava_pkg;

  localparam int unsigned NUM_CHAN = 16;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned VOL_W    = 9;
  localparam int unsigned NOTE_W   = 7;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [VOL_W-1:0]    VOL_FULL  = 9'd256;
  localparam logic [NOTE_W-1:0]   NOTE_MAX  = 7'h7F;
  localparam logic [CNT_W-1:0]    CNT_RESET = 5'd16;
  localparam logic [HANDLE_W-1:0] HANDLE_FAIL = '1;

  // register index decoded from paddr above the byte offset
  localparam logic [PADDR_W-3:0] REG_CHANNEL_COUNT = 1'b0;

  typedef enum logic [2:0] {
    OP_START_SAMPLE = 3'd0,
    OP_START_SEQ    = 3'd1,
    OP_STOP         = 3'd2,
    OP_PAUSE        = 3'd3,
    OP_RESUME       = 3'd4,
    OP_VOLUME       = 3'd5,
    OP_NOTE         = 3'd6,
    OP_QUERY        = 3'd7
  } ava_op_e;

  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_PLAYING = 2'd1,
    ST_PAUSED  = 2'd2
  } ava_status_e;

  // request travelling down the cell chain, collecting its result
  typedef struct packed {
    logic                valid;
    ava_op_e             op;
    logic [ADDR_W-1:0]   ref_req;
    logic [VALUE_W-1:0]  value;
    logic [ADDR_W-1:0]   list_ref;
    logic [ADDR_W-1:0]   order_ref;
    logic [HANDLE_W-1:0] handle;
    logic                ok;
    logic                playing;
  } ava_tok_t;

  function automatic logic is_start(ava_op_e op);
    return (op == OP_START_SAMPLE) || (op == OP_START_SEQ);
  endfunction

endpackage

`default_nettype wire

// ===== src/ava_if.sv =====
// ----------------------------------------------------------------------------
// ava_if
// valid/ready channels for allocator requests and responses
// ----------------------------------------------------------------------------
`default_nettype none

interface ava_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] ref_req;
  logic [15:0] value;
  logic [31:0] list_ref;
  logic [31:0] order_ref;

  modport source (output valid, output op, output ref_req, output value,
                  output list_ref, output order_ref, input ready);
  modport sink   (input valid, input op, input ref_req, input value,
                  input list_ref, input order_ref, output ready);
endinterface

interface ava_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [31:0] handle;
  logic        playing;

  modport source (output valid, output ok, output handle, output playing, input ready);
  modport sink   (input valid, input ok, input handle, input playing, output ready);
endinterface

`default_nettype wire

// ===== src/ava_apb.sv =====
// ----------------------------------------------------------------------------
// ava_apb
// apb register port holding the channel count
// ----------------------------------------------------------------------------
`default_nettype none

module ava_apb (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ava_pkg::PADDR_W-1:0] paddr,
  input  wire logic [ava_pkg::PDATA_W-1:0] pwdata,
  output logic      [ava_pkg::PDATA_W-1:0] prdata,
  output logic                             pready,
  output logic      [ava_pkg::CNT_W-1:0]   channel_count_o
);
  import ava_pkg::*;

  logic             cnt_sel;
  logic             cnt_we;
  logic [CNT_W-1:0] cnt_q;

  assign cnt_sel = (paddr[PADDR_W-1:2] == REG_CHANNEL_COUNT);
  assign cnt_we  = psel && penable && pwrite && cnt_sel;
  assign pready  = 1'b1;
  assign prdata  = cnt_sel ? PDATA_W'(cnt_q) : '0;
  assign channel_count_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CNT_RESET;
    end else if (cnt_we) begin
      cnt_q <= pwdata[CNT_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== src/ava_cell.sv =====
// ----------------------------------------------------------------------------
// ava_cell
// one channel of the table; claims or acts on the passing request
// ----------------------------------------------------------------------------
`default_nettype none

module ava_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_use_i,
  input  wire ava_pkg::ava_tok_t tok_i,
  output ava_pkg::ava_tok_t      tok_o
);
  import ava_pkg::*;

  ava_status_e         status_q, status_d;
  logic [HANDLE_W-1:0] handle_q, handle_d;
  logic [ADDR_W-1:0]   sample_q, sample_d;
  logic [VOL_W-1:0]    vol_q, vol_d;
  logic [NOTE_W-1:0]   note_q, note_d;
  logic                seq_q, seq_d;
  logic [ADDR_W-1:0]   list_q, list_d;
  logic [ADDR_W-1:0]   order_q, order_d;
  ava_tok_t            tok_q, tok_d;

  logic                start;
  logic                hit;
  logic [NOTE_W-1:0]   note_sat;
  logic [VOL_W-1:0]    vol_sat;

  always_comb begin
    start    = is_start(tok_i.op);
    note_sat = (tok_i.value > VALUE_W'(NOTE_MAX)) ? NOTE_MAX : tok_i.value[NOTE_W-1:0];
    vol_sat  = (tok_i.value > VALUE_W'(VOL_FULL)) ? VOL_FULL : tok_i.value[VOL_W-1:0];
    // a request already served by an earlier cell passes untouched
    hit = tok_i.valid && !tok_i.ok && in_use_i &&
          (start ? (status_q == ST_FREE)
                 : ((status_q != ST_FREE) && (handle_q == tok_i.ref_req)));
  end

  always_comb begin
    status_d = status_q;
    handle_d = handle_q;
    sample_d = sample_q;
    vol_d    = vol_q;
    note_d   = note_q;
    seq_d    = seq_q;
    list_d   = list_q;
    order_d  = order_q;
    tok_d    = tok_i;
    if (hit) begin
      tok_d.ok = 1'b1;
      unique case (tok_i.op)
        OP_START_SAMPLE: begin
          status_d = ST_PLAYING;
          handle_d = tok_i.handle;
          sample_d = tok_i.ref_req;
          vol_d    = VOL_FULL;
          note_d   = note_sat;
          seq_d    = 1'b0;
          list_d   = '0;
          order_d  = '0;
        end
        OP_START_SEQ: begin
          status_d = ST_PLAYING;
          handle_d = tok_i.handle;
          sample_d = tok_i.ref_req;
          vol_d    = VOL_FULL;
          note_d   = '0;
          seq_d    = 1'b1;
          list_d   = tok_i.list_ref;
          order_d  = tok_i.order_ref;
        end
        OP_STOP:   status_d = ST_FREE;
        OP_PAUSE:  status_d = ST_PAUSED;
        OP_RESUME: begin
          if (status_q == ST_PAUSED) begin
            status_d = ST_PLAYING;
          end
        end
        OP_VOLUME: vol_d = vol_sat;
        OP_NOTE:   note_d = note_sat;
        OP_QUERY:  tok_d.playing = 1'b1;
        default:   status_d = status_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= ST_FREE;
      tok_q    <= '0;
    end else begin
      status_q <= status_d;
      tok_q    <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    handle_q <= handle_d;
    sample_q <= sample_d;
    vol_q    <= vol_d;
    note_q   <= note_d;
    seq_q    <= seq_d;
    list_q   <= list_d;
    order_q  <= order_d;
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

// ===== src/audio_voice_allocator_top.sv =====
// Path: a request is registered by each channel cell in turn, from the request
// transfer edge on, and then by the response register.
// Requests: one at a time; the next is taken the cycle after the response
// transfer.
// Reset: all channels free, channel_count 16, handle counter 0.
// ----------------------------------------------------------------------------
// audio_voice_allocator_top
// sound channel table built as a chain of channel cells with an apb port
// ----------------------------------------------------------------------------
`default_nettype none

`include "audio_voice_allocator_top_defines.svh"

module audio_voice_allocator_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  ava_req_if.sink                          req_i,
  ava_rsp_if.source                        rsp_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ava_pkg::PADDR_W-1:0] paddr,
  input  wire logic [ava_pkg::PDATA_W-1:0] pwdata,
  output logic      [ava_pkg::PDATA_W-1:0] prdata,
  output logic                             pready
);
  import ava_pkg::*;

  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    cnt_eff;
  logic [NUM_CHAN-1:0] in_use;
  ava_tok_t            tok [NUM_CHAN+1];
  logic [NUM_CHAN-1:0] tok_vld;
  ava_tok_t            tok_end;
  ava_op_e             req_op;

  logic                busy_q;
  logic [HANDLE_W-1:0] next_handle_q;
  logic                out_vld_q;
  logic                out_ok_q;
  logic [HANDLE_W-1:0] out_handle_q;
  logic                out_playing_q;
  logic                req_xfer;
  logic                rsp_xfer;
  logic                start_done;

  ava_apb u_apb (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .channel_count_o (cnt)
  );

  assign cnt_eff = (cnt > CNT_W'(NUM_CHAN)) ? CNT_W'(NUM_CHAN) : cnt;

  assign req_i.ready = !busy_q;
  assign req_xfer    = req_i.valid && req_i.ready;
  assign rsp_xfer    = rsp_o.valid && rsp_o.ready;
  assign req_op      = ava_op_e'(req_i.op);

  always_comb begin
    tok[0]           = '0;
    tok[0].valid     = req_xfer;
    tok[0].op        = req_op;
    tok[0].ref_req   = req_i.ref_req;
    tok[0].value     = req_i.value;
    tok[0].list_ref  = req_i.list_ref;
    tok[0].order_ref = req_i.order_ref;
    // starts carry the handle they would be given
    tok[0].handle    = is_start(req_op) ? next_handle_q : req_i.ref_req;
  end

  for (genvar i = 0; i < NUM_CHAN; i++) begin : g_cell
    assign in_use[i]  = (CNT_W'(i) < cnt_eff);
    assign tok_vld[i] = tok[i+1].valid;
    ava_cell u_cell (
      .clk_i,
      .rst_ni,
      .in_use_i (in_use[i]),
      .tok_i    (tok[i]),
      .tok_o    (tok[i+1])
    );
  end

  assign tok_end    = tok[NUM_CHAN];
  assign start_done = tok_end.valid && tok_end.ok && is_start(tok_end.op);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q        <= 1'b0;
      out_vld_q     <= 1'b0;
      next_handle_q <= '0;
    end else begin
      if (req_xfer) begin
        busy_q <= 1'b1;
      end else if (rsp_xfer) begin
        busy_q <= 1'b0;
      end
      if (tok_end.valid) begin
        out_vld_q <= 1'b1;
      end else if (rsp_xfer) begin
        out_vld_q <= 1'b0;
      end
      if (start_done) begin
        next_handle_q <= next_handle_q + HANDLE_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_end.valid) begin
      out_ok_q      <= tok_end.ok;
      out_playing_q <= tok_end.playing;
      out_handle_q  <= (is_start(tok_end.op) && !tok_end.ok) ? HANDLE_FAIL : tok_end.handle;
    end
  end

  assign rsp_o.valid   = out_vld_q;
  assign rsp_o.ok      = out_ok_q;
  assign rsp_o.handle  = out_handle_q;
  assign rsp_o.playing = out_playing_q;

  `AVA_ASSERT_ALWAYS(a_one_request_in_chain, $countones(tok_vld) <= 1, "several requests in chain")
  `AVA_ASSERT(a_idle_chain_empty, req_i.ready |-> (tok_vld == '0), "ready with request in chain")
  `AVA_ASSERT(a_rsp_only_when_busy, rsp_o.valid |-> busy_q, "response without request")
  `AVA_ASSERT(a_handle_advances, start_done |=> (next_handle_q == $past(next_handle_q) + 32'd1), "handle counter did not advance")

endmodule

`default_nettype wire

// ===== sim/audio_voice_allocator_top_tb.sv =====
// ----------------------------------------------------------------------------
// audio_voice_allocator_top_tb
// drives channel requests and apb writes into the allocator, predicts each
// response from the local table or a directed row; checks each field in order
// ----------------------------------------------------------------------------
module audio_voice_allocator_top_tb;
  import ava_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DIR_ROWS     = 31;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 140;
  localparam int PHASE_CNT [PHASES] = '{16, 3, 31, 1, 9, 16, 2, 0};

  // index with no register behind it, writes must be dropped
  localparam logic [PADDR_W-3:0] REG_SPARE = 1'b1;

  typedef struct packed {
    ava_op_e             op;
    logic [ADDR_W-1:0]   ref_req;
    logic [VALUE_W-1:0]  value;
    logic [ADDR_W-1:0]   list_ref;
    logic [ADDR_W-1:0]   order_ref;
  } alloc_req_t;

  typedef struct packed {
    logic                ok;
    logic [HANDLE_W-1:0] handle;
    logic                playing;
  } alloc_rsp_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  // cfg rows carry the register index in ref_req and the data in value
  typedef struct packed {
    row_kind_e           kind;
    ava_op_e             op;
    logic [ADDR_W-1:0]   ref_req;
    logic [VALUE_W-1:0]  value;
    logic [ADDR_W-1:0]   list_ref;
    logic [ADDR_W-1:0]   order_ref;
    logic                typed_on;
    logic                ok;
    logic [HANDLE_W-1:0] handle;
    logic                playing;
  } dir_row_t;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_REQ, OP_QUERY,        32'h0,        16'h0,    32'h0,  32'h0,  1'b1, 1'b0, 32'h0, 1'b0},
    '{ROW_REQ, OP_START_SAMPLE, 32'hFFFFFFFF, 16'hFFFF, 32'h0,  32'h0,  1'b1, 1'b1, 32'h0, 1'b0},
    '{ROW_REQ, OP_START_SEQ,    32'h0,        16'hFFFF, '1,     32'h0,  1'b1, 1'b1, 32'h1, 1'b0},
    '{ROW_REQ, OP_START_SEQ,    32'h12345678, 16'h0,    32'h0,  '1,     1'b1, 1'b1, 32'h2, 1'b0},
    '{ROW_REQ, OP_START_SAMPLE, 32'hA5A5A5A5, 16'h007F, 32'h0,  32'h0,  1'b1, 1'b1, 32'h3, 1'b0},
    '{ROW_REQ, OP_START_SAMPLE, 32'h5A5A5A5A, 16'h0080, 32'h0,  32'h0,  1'b1, 1'b1, 32'h4, 1'b0},
    '{ROW_REQ, OP_VOLUME,       32'h0,        16'hFFFF, 32'h0,  32'h0,  1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_REQ, OP_VOLUME,       32'h1,        16'h0100, 32'h0,  32'h0,  1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_REQ, OP_VOLUME,       32'h2,        16'h0101, 32'h0,  32'h0,  1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_REQ, OP_NOTE,         32'h3,        16'h0080, 32'h0,  32'h0,  1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_REQ, OP_NOTE,         32'h4,        16'h0000, 32'h0,  32'h0,  1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_REQ, OP_PAUSE,        32'h0,        16'h0,    32'h0,  32'h0,  1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_REQ, OP_PAUSE,        32'h0,        16'h0,    32'h0,  32'h0,  1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_REQ, OP_QUERY,        32'h0,        16'h0,    32'h0,  32'h0,  1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_REQ, OP_RESUME,       32'h0,        16'h0,    32'h0,  32'h0,  1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_REQ, OP_RESUME,       32'h1,        16'h0,    32'h0,  32'h0,  1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_REQ, OP_STOP,         32'h1,        16'h0,    32'h0,  32'h0,  1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_REQ, OP_QUERY,        32'h1,        16'h0,    32'h0,  32'h0,  1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_REQ, OP_STOP,         32'hFFFFFFFF, 16'h0,    32'h0,  32'h0,  1'b1, 1'b0, '1,    1'b0},
    '{ROW_REQ, OP_START_SAMPLE, 32'h0,        16'h0,    32'h0,  32'h0,  1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_REQ, OP_QUERY,        32'h5,        16'h0,    32'h0,  32'h0,  1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_CFG, OP_QUERY, 32'(REG_CHANNEL_COUNT), 16'd1, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_REQ, OP_START_SAMPLE, 32'h0,        16'h0,    32'h0,  32'h0,  1'b1, 1'b0, '1,    1'b0},
    '{ROW_REQ, OP_QUERY,        32'h2,        16'h0,    32'h0,  32'h0,  1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_CFG, OP_QUERY, 32'(REG_SPARE),         16'd0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_REQ, OP_QUERY,        32'h0,        16'h0,    32'h0,  32'h0,  1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_CFG, OP_QUERY, 32'(REG_CHANNEL_COUNT), 16'd0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_REQ, OP_START_SEQ,    32'hFFFFFFFF, 16'hFFFF, '1,     '1,     1'b1, 1'b0, '1,    1'b0},
    '{ROW_REQ, OP_QUERY,        32'h0,        16'h0,    32'h0,  32'h0,  1'b1, 1'b0, 32'h0, 1'b0},
    '{ROW_CFG, OP_QUERY, 32'(REG_CHANNEL_COUNT), 16'd31, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_REQ, OP_QUERY,        32'h2,        16'h0,    32'h0,  32'h0,  1'b0, 1'b0, 32'h0, 1'b0}
  };

  logic clk_i;
  logic rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  ava_req_if req_if ();
  ava_rsp_if rsp_if ();

  audio_voice_allocator_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // local copy of the channel table
  ava_status_e         chan_state [NUM_CHAN];
  logic [HANDLE_W-1:0] chan_id    [NUM_CHAN];
  logic [HANDLE_W-1:0] handle_ctr;
  logic [CNT_W-1:0]    chan_limit;

  alloc_rsp_t rsp_due [$];
  logic       typed_on;
  alloc_rsp_t typed_rsp;

  int gap_pct;
  int stall_pct;
  int errors;
  int cycles;
  int n_accepted;
  int n_checked;
  int n_refused;

  function automatic alloc_rsp_t alloc_predict(alloc_req_t r);
    alloc_rsp_t res;
    int         n;
    int         hit;
    n = (chan_limit > NUM_CHAN) ? NUM_CHAN : int'(chan_limit);
    hit = -1;
    res.ok = 1'b0;
    res.handle = r.ref_req;
    res.playing = 1'b0;
    if (r.op == OP_START_SAMPLE || r.op == OP_START_SEQ) begin
      for (int i = 0; i < n; i++) begin
        if (hit < 0 && chan_state[i] == ST_FREE) hit = i;
      end
      if (hit < 0) begin
        res.handle = HANDLE_FAIL;
        n_refused++;
      end else begin
        chan_state[hit] = ST_PLAYING;
        chan_id[hit] = handle_ctr;
        res.handle = handle_ctr;
        res.ok = 1'b1;
        handle_ctr = handle_ctr + 1;
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        if (hit < 0 && chan_state[i] != ST_FREE && chan_id[i] == r.ref_req) hit = i;
      end
      if (hit >= 0) begin
        res.ok = 1'b1;
        case (r.op)
          OP_STOP: chan_state[hit] = ST_FREE;
          OP_PAUSE: chan_state[hit] = ST_PAUSED;
          OP_RESUME: begin
            if (chan_state[hit] == ST_PAUSED) chan_state[hit] = ST_PLAYING;
          end
          OP_QUERY: res.playing = 1'b1;
          default: ;
        endcase
      end
    end
    return res;
  endfunction

  // mostly handles issued lately, so stop/pause/query actually land
  function automatic logic [HANDLE_W-1:0] pick_handle();
    int sel;
    int span;
    sel = $urandom_range(99);
    span = (handle_ctr > 20) ? 20 : int'(handle_ctr);
    if (sel < 80 && span > 0) return handle_ctr - 1 - $urandom_range(span - 1);
    if (sel < 92) return $urandom;
    return (sel[0]) ? '1 : '0;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] edges [6] = '{16'd126, 16'd127, 16'd128, 16'd255, 16'd256, 16'd257};
    case ($urandom_range(3))
      0: return VALUE_W'($urandom_range(300));
      1: return VALUE_W'($urandom);
      2: return edges[$urandom_range(5)];
      default: return VALUE_W'($urandom_range(127));
    endcase
  endfunction

  function automatic alloc_req_t make_random_req();
    alloc_req_t r;
    int         sel;
    sel = $urandom_range(99);
    if (sel < 20) r.op = OP_START_SAMPLE;
    else if (sel < 32) r.op = OP_START_SEQ;
    else if (sel < 50) r.op = OP_STOP;
    else if (sel < 60) r.op = OP_PAUSE;
    else if (sel < 70) r.op = OP_RESUME;
    else if (sel < 78) r.op = OP_VOLUME;
    else if (sel < 86) r.op = OP_NOTE;
    else r.op = OP_QUERY;
    r.ref_req = (r.op == OP_START_SAMPLE || r.op == OP_START_SEQ) ? $urandom : pick_handle();
    r.value = pick_value();
    r.list_ref = $urandom;
    r.order_ref = $urandom;
    return r;
  endfunction

  // called and left at a falling edge
  task automatic send_req(input alloc_req_t r, input logic use_typed, input alloc_rsp_t typed);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk_i);
    end
    req_if.valid = 1'b1;
    req_if.op = r.op;
    req_if.ref_req = r.ref_req;
    req_if.value = r.value;
    req_if.list_ref = r.list_ref;
    req_if.order_ref = r.order_ref;
    typed_on = use_typed;
    typed_rsp = typed;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    req_if.valid = 1'b0;
    while (rsp_due.size() != 0) @(negedge clk_i);
  endtask

  // apb write, then read back channel_count
  task automatic cfg_write(input logic [PADDR_W-3:0] idx, input logic [PDATA_W-1:0] data);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == REG_CHANNEL_COUNT) chan_limit = data[CNT_W-1:0];
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk_i);
    psel = 1'b1;
    paddr = {REG_CHANNEL_COUNT, 2'b00};
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[CNT_W-1:0] !== chan_limit) begin
      $error("channel_count mismatch: expected %0d, actual %0d", chan_limit,
             prdata[CNT_W-1:0]);
      errors++;
    end
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // receiver side: stall decided once per cycle
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_if.ready = !(stall_pct != 0 && $urandom_range(99) < stall_pct);
    end
  end

  // predict on each request transfer, check on each response transfer
  always @(posedge clk_i) begin : mon
    alloc_rsp_t want;
    alloc_rsp_t guess;
    alloc_req_t seen;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (rsp_due.size() == 0) begin
          $error("response transfer with nothing outstanding: handle %h", rsp_if.handle);
          errors++;
        end else begin
          want = rsp_due.pop_front();
          n_checked++;
          if (rsp_if.ok !== want.ok) begin
            $error("ok mismatch: expected %0d, actual %0d", want.ok, rsp_if.ok);
            errors++;
          end
          if (rsp_if.handle !== want.handle) begin
            $error("handle mismatch: expected %h, actual %h", want.handle, rsp_if.handle);
            errors++;
          end
          if (rsp_if.playing !== want.playing) begin
            $error("playing mismatch: expected %0d, actual %0d", want.playing,
                   rsp_if.playing);
            errors++;
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        seen.op = ava_op_e'(req_if.op);
        seen.ref_req = req_if.ref_req;
        seen.value = req_if.value;
        seen.list_ref = req_if.list_ref;
        seen.order_ref = req_if.order_ref;
        guess = alloc_predict(seen);
        n_accepted++;
        rsp_due.push_back(typed_on ? typed_rsp : guess);
      end
    end
  end

  initial begin : stim
    alloc_req_t r;
    alloc_rsp_t t;
    int         cnt;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.op = OP_QUERY;
    req_if.ref_req = '0;
    req_if.value = '0;
    req_if.list_ref = '0;
    req_if.order_ref = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    typed_on = 1'b0;
    typed_rsp = '0;
    gap_pct = 0;
    stall_pct = 0;
    errors = 0;
    n_accepted = 0;
    n_checked = 0;
    n_refused = 0;
    handle_ctr = '0;
    chan_limit = CNT_RESET;
    for (int i = 0; i < NUM_CHAN; i++) begin
      chan_state[i] = ST_FREE;
      chan_id[i] = '0;
    end
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        drain_results();
        cfg_write(dir_tab[i].ref_req[PADDR_W-3:0], PDATA_W'(dir_tab[i].value));
      end else begin
        r.op = dir_tab[i].op;
        r.ref_req = dir_tab[i].ref_req;
        r.value = dir_tab[i].value;
        r.list_ref = dir_tab[i].list_ref;
        r.order_ref = dir_tab[i].order_ref;
        t.ok = dir_tab[i].ok;
        t.handle = dir_tab[i].handle;
        t.playing = dir_tab[i].playing;
        send_req(r, dir_tab[i].typed_on, t);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      cnt = (ph == PHASES - 1) ? $urandom_range(1, NUM_CHAN) : PHASE_CNT[ph];
      cfg_write(REG_CHANNEL_COUNT, PDATA_W'(cnt));
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 45; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 45; end
        default: begin gap_pct = 20; stall_pct = 20; end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // now and then hold off until the table has answered everything
        if ($urandom_range(39) == 0) drain_results();
        send_req(make_random_req(), 1'b0, '0);
      end
    end

    drain_results();
    gap_pct = 0;
    stall_pct = 0;
    repeat (40) @(posedge clk_i);

    $display("checked %0d responses to %0d requests in %0d cycles", n_checked, n_accepted,
             cycles);
    $display("%0d starts refused for lack of a free channel, %0d handles issued",
             n_refused, handle_ctr);
    if (errors == 0 && rsp_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/ava_pkg.sv
src/ava_if.sv
src/ava_apb.sv
src/ava_cell.sv
src/audio_voice_allocator_top.sv
sim/audio_voice_allocator_top_tb.sv
